### src/substring_search_stream_macros.svh
// Assertion macros for the substring search stream block.
// Used by the top level only; no other dependencies.
`ifndef SUBSTRING_SEARCH_STREAM_MACROS_SVH
`define SUBSTRING_SEARCH_STREAM_MACROS_SVH

`ifndef SYNTHESIS
// combinational check, sampled every clock outside reset
`define SSS_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// implication checked in the cycle after the antecedent
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSS_ASSERT(lbl, clk, rst_n, expr, msg)
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/sss_pkg.sv
// Shared types, constants and helpers for the substring search stream.
// No dependencies.
package sss_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int PATTERN_BYTES   = 32;   // bytes held by the four pattern words
    localparam int PAT_IDX_W       = 5;
    localparam int LEN_W           = 6;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int OFFSET_W        = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_0   = 3'd0,
        CFG_PATTERN_1   = 3'd1,
        CFG_PATTERN_2   = 3'd2,
        CFG_PATTERN_3   = 3'd3,
        CFG_PATTERN_LEN = 3'd4,
        CFG_FOLD_CASE   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } t_out_item;

    // compare controls that travel with the aligned pattern
    typedef struct packed {
        logic [LEN_W-1:0] len;    // clamped pattern length
        logic             fold;
    } t_match_ctrl;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

### src/sss_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is a parameter; types come from sss_pkg at the instance.
interface sss_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/substring_search_stream.sv
// Substring search stream: bytes register in the cell chain (stage 0), results in
// the output register (stage 1); one text byte per cycle unless output stalls.
// History shifts through MAX_PATTERN cells, each comparing in parallel with the pattern.
// Synchronous active-low reset clears the pattern registers (length 1, no
// folding), the byte count, the reported flag and both stages' valid flags.
// Depends on sss_pkg, sss_stream_if, sss_pattern_align, sss_cell and the macros.
`include "substring_search_stream_macros.svh"

module substring_search_stream #(
    parameter int MAX_PATTERN = sss_pkg::MAX_PATTERN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    sss_stream_if.sink                        i_in,
    sss_stream_if.source                      o_res
);

    localparam int OW = sss_pkg::OFFSET_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [3:0][sss_pkg::CFG_DATA_W-1:0]   r_pat_words;
    logic [sss_pkg::LEN_W-1:0]             r_len_raw;
    logic                                  r_fold;
    logic [sss_pkg::PATTERN_BYTES-1:0][7:0] w_pattern;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_words <= '0;
            r_len_raw   <= sss_pkg::LEN_W'(1);
            r_fold      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                sss_pkg::CFG_PATTERN_0, sss_pkg::CFG_PATTERN_1,
                sss_pkg::CFG_PATTERN_2, sss_pkg::CFG_PATTERN_3: begin
                    r_pat_words[i_cfg_index[1:0]] <= i_cfg_data;
                end
                sss_pkg::CFG_PATTERN_LEN: begin
                    r_len_raw <= i_cfg_data[sss_pkg::LEN_W-1:0];
                end
                sss_pkg::CFG_FOLD_CASE: begin
                    r_fold <= i_cfg_data[0];
                end
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    assign w_pattern = r_pat_words;

    // aligned pattern, one register stage behind the config
    logic [MAX_PATTERN-1:0][7:0] w_pat_bytes;
    logic [MAX_PATTERN-1:0]      w_care;
    sss_pkg::t_match_ctrl        w_ctrl;

    sss_pattern_align #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_align (
        .i_clk       (i_clk),
        .i_pattern   (w_pattern),
        .i_len_raw   (r_len_raw),
        .i_fold      (r_fold),
        .o_pat_bytes (w_pat_bytes),
        .o_care      (w_care),
        .o_ctrl      (w_ctrl)
    );

    // ---------------------------------------------------------------
    // Stage 0: byte shifts into the cell chain on each input transfer
    // ---------------------------------------------------------------
    logic          r_s0_valid;
    logic          r_s0_last;     // flag of the most recent accepted byte
    logic [OW-1:0] r_seen;        // bytes of current text, saturating
    logic          w_in_xfer;
    logic          w_advance;

    logic [MAX_PATTERN:0][7:0] w_chain;
    logic [MAX_PATTERN-1:0]    w_eq;

    assign w_advance  = !o_res.valid || o_res.ready;
    assign i_in.ready = !r_s0_valid || w_advance;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_chain[0] = i_in.data.text_byte;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        sss_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_in_xfer),
            .i_byte     (w_chain[j]),
            .i_pat_byte (w_pat_bytes[j]),
            .i_care     (w_care[j]),
            .i_fold     (w_ctrl.fold),
            .o_byte     (w_chain[j+1]),
            .o_eq       (w_eq[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s0_last  <= 1'b0;
            r_seen     <= '0;
        end else begin
            if (w_in_xfer) begin
                r_s0_valid <= 1'b1;
                r_s0_last  <= i_in.data.end_of_text;
                // a new text starts counting after the previous last byte
                if (r_s0_last) begin
                    r_seen <= OW'(1);
                end else if (r_seen != '1) begin
                    r_seen <= r_seen + OW'(1);
                end
            end else if (w_advance) begin
                r_s0_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: match decision into the output register
    // ---------------------------------------------------------------
    logic               r_match_reported;
    logic               r_out_valid;
    sss_pkg::t_out_item r_out_data;
    logic               w_hit;
    logic               w_not_found;

    assign w_hit = r_s0_valid && !r_match_reported
                   && (r_seen >= OW'(w_ctrl.len)) && (&w_eq);
    assign w_not_found = r_s0_valid && r_s0_last && !r_match_reported && !w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_reported <= 1'b0;
            r_out_valid      <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_hit || w_not_found;
            if (r_s0_valid) begin
                r_match_reported <= !r_s0_last && (r_match_reported || w_hit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data.found        <= w_hit;
            r_out_data.match_offset <= w_hit ? (r_seen - OW'(w_ctrl.len)) : '0;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `SSS_ASSERT(a_nf_zero_offset, i_clk, i_rst_n, !r_out_valid || r_out_data.found || (r_out_data.match_offset == '0), "not-found result with nonzero offset")
    `SSS_ASSERT(a_seen_nonzero, i_clk, i_rst_n, !r_s0_valid || (r_seen != '0), "stage 0 holds a byte but count is zero")
    `SSS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_s0_valid && !w_advance, r_s0_valid && $stable(r_seen) && $stable(r_s0_last), "stalled stage 0 changed")

endmodule

### src/sss_pattern_align.sv
// Lines the pattern up with the history cells: cell j sees pattern byte len-1-j.
// Depends on sss_pkg. Output is registered and refreshed every cycle.
module sss_pattern_align #(
    parameter int MAX_PATTERN = sss_pkg::MAX_PATTERN_DEF
) (
    input  logic                                      i_clk,
    input  logic [sss_pkg::PATTERN_BYTES-1:0][7:0]    i_pattern,
    input  logic [sss_pkg::LEN_W-1:0]                 i_len_raw,
    input  logic                                      i_fold,
    output logic [MAX_PATTERN-1:0][7:0]               o_pat_bytes,
    output logic [MAX_PATTERN-1:0]                    o_care,
    output sss_pkg::t_match_ctrl                      o_ctrl
);

    localparam logic [sss_pkg::LEN_W-1:0] MaxLen = sss_pkg::LEN_W'(MAX_PATTERN);

    logic [sss_pkg::LEN_W-1:0]         w_len;
    logic [MAX_PATTERN-1:0][7:0]       n_pat_bytes;
    logic [MAX_PATTERN-1:0]            n_care;
    logic [MAX_PATTERN-1:0][7:0]       r_pat_bytes;
    logic [MAX_PATTERN-1:0]            r_care;
    sss_pkg::t_match_ctrl              r_ctrl;

    // zero counts as one, anything past the cell count as the cell count
    always_comb begin
        w_len = i_len_raw;
        if (i_len_raw == '0) begin
            w_len = sss_pkg::LEN_W'(1);
        end else if (i_len_raw > MaxLen) begin
            w_len = MaxLen;
        end
    end

    always_comb begin
        logic [sss_pkg::LEN_W-1:0] idx;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            idx            = w_len - sss_pkg::LEN_W'(1) - sss_pkg::LEN_W'(j);
            n_care[j]      = (sss_pkg::LEN_W'(j) < w_len);
            n_pat_bytes[j] = sss_pkg::fold_byte(i_pattern[idx[sss_pkg::PAT_IDX_W-1:0]],
                                                i_fold);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat_bytes <= n_pat_bytes;
        r_care      <= n_care;
        r_ctrl.len  <= w_len;
        r_ctrl.fold <= i_fold;
    end

    assign o_pat_bytes = r_pat_bytes;
    assign o_care      = r_care;
    assign o_ctrl      = r_ctrl;

endmodule

### src/sss_cell.sv
// One history cell: holds a text byte, passes it on when a byte shifts in,
// and compares it with its aligned pattern byte. Depends on sss_pkg.
module sss_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat_byte,
    input  logic       i_care,
    input  logic       i_fold,
    output logic [7:0] o_byte,
    output logic       o_eq
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = !i_care || (sss_pkg::fold_byte(r_byte, i_fold) == i_pat_byte);

endmodule
